/* rtl/ccot_pkg.sv */
package ccot_pkg;

  localparam int COORD_WIDTH    = 16;
  localparam int FRACTION_BITS  = 16;

  localparam int CFG_WIDTH      = 32;
  localparam int CFG_ADDR_WIDTH = 2;
  localparam logic [CFG_ADDR_WIDTH-1:0] REG_TOL   = CFG_ADDR_WIDTH'(0);
  localparam logic [CFG_WIDTH-1:0]      TOL_RESET = 32'd500000000;

  localparam int DIFW = COORD_WIDTH + 1;
  localparam int EW   = COORD_WIDTH + 2;
  localparam int PRW  = 2 * DIFW;
  localparam int DSW  = 2 * DIFW + 2;
  localparam int DMW  = DSW - 1;
  localparam int BW   = 2 * DIFW;
  localparam int EWW  = 2 * EW;
  localparam int M2W  = EWW;
  localparam int PW   = BW + 1 + DIFW;
  localparam int NSW  = PW + 1;
  localparam int NMW  = NSW - 1;
  localparam int QW   = NMW + FRACTION_BITS;
  localparam int TPW  = DMW + CFG_WIDTH;

  localparam int OFF_MAGW = 63;
  localparam logic [OFF_MAGW-1:0] OFFSET_LIMIT = OFF_MAGW'(1) << 62;
  localparam int QXW   = (QW > OFF_MAGW) ? QW + 1 : OFF_MAGW + 1;

  localparam int CENW  = 48;
  localparam int RADW  = 47;
  localparam int OXW   = 64;
  localparam int CSUMW = OXW + 1;
  localparam logic signed [CENW-1:0] CEN_MAX = {1'b0, {(CENW-1){1'b1}}};
  localparam logic signed [CENW-1:0] CEN_MIN = {1'b1, {(CENW-1){1'b0}}};
  localparam logic [RADW-1:0] RAD_MAX = {RADW{1'b1}};
  localparam logic [OFF_MAGW-1:0] RAD_LIMIT = OFF_MAGW'(1) << RADW;

  localparam int SPLIT = 24;
  localparam int HIW   = RADW - SPLIT;
  localparam int SQW   = 2 * RADW;
  localparam int RTW   = RADW + 1;
  localparam int VW    = 2 * RTW;
  localparam int RW    = RTW + 3;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] point_a_x;
    logic signed [COORD_WIDTH-1:0] point_a_y;
    logic signed [COORD_WIDTH-1:0] point_b_x;
    logic signed [COORD_WIDTH-1:0] point_b_y;
    logic signed [COORD_WIDTH-1:0] point_c_x;
    logic signed [COORD_WIDTH-1:0] point_c_y;
  } in_item_t;

  typedef struct packed {
    logic signed [CENW-1:0] centre_x;
    logic signed [CENW-1:0] centre_y;
    logic [RADW-1:0]        circle_radius;
    logic                   is_collinear;
  } out_item_t;

  typedef struct packed {
    logic [DMW-1:0] rem;
    logic [QW-1:0]  quo;
    logic [QW-1:0]  num;
    logic [DMW-1:0] den;
  } div_lane_t;

  typedef struct packed {
    logic [RW-1:0]  rem;
    logic [RTW-1:0] root;
    logic [VW-1:0]  val;
  } sqrt_lane_t;

endpackage

/* rtl/circumcircle_of_triangle.sv */
// Circumcircle of three points. An item is taken on any cycle start is high; busy
// is always low, so one item per cycle is sustained and the receiver cannot stall.
// Each item yields one result, strobed on out_strobe for one cycle, after it has passed
// through six front stages (differences, products, determinant, tolerance test),
// a chain of 68 one-bit divider cells per coordinate, four stages of rounding,
// centre saturation and squaring, a chain of 48 two-bit square root cells, and the
// output register. The tolerance register at APB offset 0 is read by the front
// stages and should only be written while no item is in flight.
module circumcircle_of_triangle (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  output logic                                  busy,
  input  ccot_pkg::in_item_t                    in_item,
  output logic                                  out_strobe,
  output ccot_pkg::out_item_t                   out_result,
  input  logic                                  cfg_psel,
  input  logic                                  cfg_penable,
  input  logic                                  cfg_pwrite,
  input  logic [ccot_pkg::CFG_ADDR_WIDTH-1:0]   cfg_paddr,
  input  logic [ccot_pkg::CFG_WIDTH-1:0]        cfg_pwdata,
  output logic [ccot_pkg::CFG_WIDTH-1:0]        cfg_prdata,
  output logic                                  cfg_pready
);
  import ccot_pkg::*;

  typedef struct packed {
    logic                          v;
    logic                          coll;
    logic                          negx;
    logic                          negy;
    logic signed [COORD_WIDTH-1:0] ax;
    logic signed [COORD_WIDTH-1:0] ay;
  } sb1_t;

  typedef struct packed {
    logic                   v;
    logic                   coll;
    logic                   sat;
    logic signed [CENW-1:0] cx;
    logic signed [CENW-1:0] cy;
  } sb2_t;

  logic [CFG_WIDTH-1:0] tol_r;

  assign busy       = 1'b0;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == REG_TOL) ? tol_r : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= TOL_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == REG_TOL) begin
      tol_r <= cfg_pwdata;
    end
  end

  // front stages
  logic [6:1] fv_r;
  logic signed [DIFW-1:0] bx_r, by_r, cx_r, cy_r;
  logic signed [DIFW-1:0] bx2_r, by2_r, cx2_r, cy2_r;
  logic signed [DIFW-1:0] bx3_r, by3_r, cx3_r, cy3_r;
  logic signed [EW-1:0] ex_r, ey_r;
  logic signed [COORD_WIDTH-1:0] ax_r [1:6];
  logic signed [COORD_WIDTH-1:0] ay_r [1:6];
  logic signed [PRW-1:0] bc_r, bycx_r;
  logic [PRW-1:0] bxx_r, byy_r, cxx_r, cyy_r;
  logic [EWW-1:0] exx_r, eyy_r;
  logic signed [DSW-1:0] d_r;
  logic [BW-1:0] bb_r, cc_r;
  logic [EWW-1:0] ee_r;
  logic [DMW-1:0] dm4_r, dm5_r;
  logic dneg4_r, dneg5_r;
  logic [M2W-1:0] m2_4_r, m2_5_r;
  logic signed [PW-1:0] bcy_r, cby_r, cbx_r, bcx_r;
  logic [TPW-1:0] tolp_r;
  logic signed [NSW-1:0] nx_r, ny_r;
  logic coll6_r, negx6_r, negy6_r;
  logic [QW-1:0] numx6_r, numy6_r;
  logic [DMW-1:0] dm6_r;
  logic [M2W-1:0] m2_nxt;

  always_comb begin
    m2_nxt = M2W'(bb_r);
    if (M2W'(cc_r) > m2_nxt) begin
      m2_nxt = M2W'(cc_r);
    end
    if (ee_r > m2_nxt) begin
      m2_nxt = ee_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= '0;
    end else begin
      fv_r <= {fv_r[5:1], start};
    end
  end

  always_ff @(posedge clk) begin
    bx_r     <= DIFW'(in_item.point_b_x) - DIFW'(in_item.point_a_x);
    by_r     <= DIFW'(in_item.point_b_y) - DIFW'(in_item.point_a_y);
    cx_r     <= DIFW'(in_item.point_c_x) - DIFW'(in_item.point_a_x);
    cy_r     <= DIFW'(in_item.point_c_y) - DIFW'(in_item.point_a_y);
    ex_r     <= EW'(in_item.point_c_x) - EW'(in_item.point_b_x);
    ey_r     <= EW'(in_item.point_c_y) - EW'(in_item.point_b_y);
    ax_r[1]  <= in_item.point_a_x;
    ay_r[1]  <= in_item.point_a_y;
    for (int i = 2; i <= 6; i++) begin
      ax_r[i] <= ax_r[i-1];
      ay_r[i] <= ay_r[i-1];
    end

    bc_r   <= PRW'(bx_r) * PRW'(cy_r);
    bycx_r <= PRW'(by_r) * PRW'(cx_r);
    bxx_r  <= PRW'(bx_r) * PRW'(bx_r);
    byy_r  <= PRW'(by_r) * PRW'(by_r);
    cxx_r  <= PRW'(cx_r) * PRW'(cx_r);
    cyy_r  <= PRW'(cy_r) * PRW'(cy_r);
    exx_r  <= EWW'(ex_r) * EWW'(ex_r);
    eyy_r  <= EWW'(ey_r) * EWW'(ey_r);
    bx2_r  <= bx_r;
    by2_r  <= by_r;
    cx2_r  <= cx_r;
    cy2_r  <= cy_r;

    d_r   <= (DSW'(bc_r) - DSW'(bycx_r)) <<< 1;
    bb_r  <= BW'(bxx_r) + BW'(byy_r);
    cc_r  <= BW'(cxx_r) + BW'(cyy_r);
    ee_r  <= exx_r + eyy_r;
    bx3_r <= bx2_r;
    by3_r <= by2_r;
    cx3_r <= cx2_r;
    cy3_r <= cy2_r;

    dm4_r   <= d_r[DSW-1] ? DMW'(-d_r) : DMW'(d_r);
    dneg4_r <= d_r[DSW-1];
    m2_4_r  <= m2_nxt;
    bcy_r   <= PW'($signed({1'b0, bb_r})) * PW'(cy3_r);
    cby_r   <= PW'($signed({1'b0, cc_r})) * PW'(by3_r);
    cbx_r   <= PW'($signed({1'b0, cc_r})) * PW'(bx3_r);
    bcx_r   <= PW'($signed({1'b0, bb_r})) * PW'(cx3_r);

    tolp_r  <= TPW'(dm4_r) * TPW'(tol_r);
    nx_r    <= NSW'(bcy_r) - NSW'(cby_r);
    ny_r    <= NSW'(cbx_r) - NSW'(bcx_r);
    dm5_r   <= dm4_r;
    dneg5_r <= dneg4_r;
    m2_5_r  <= m2_4_r;

    coll6_r <= (dm5_r == '0) || (TPW'(m2_5_r) > tolp_r);
    negx6_r <= nx_r[NSW-1] ^ dneg5_r;
    negy6_r <= ny_r[NSW-1] ^ dneg5_r;
    numx6_r <= QW'(nx_r[NSW-1] ? NMW'(-nx_r) : NMW'(nx_r)) << FRACTION_BITS;
    numy6_r <= QW'(ny_r[NSW-1] ? NMW'(-ny_r) : NMW'(ny_r)) << FRACTION_BITS;
    dm6_r   <= dm5_r;
  end

  // divider chains
  div_lane_t dx_lane [QW+1];
  div_lane_t dy_lane [QW+1];
  sb1_t      sb1_r [QW];
  sb1_t      sb1_in;

  assign dx_lane[0] = '{rem: '0, quo: '0, num: numx6_r, den: dm6_r};
  assign dy_lane[0] = '{rem: '0, quo: '0, num: numy6_r, den: dm6_r};
  assign sb1_in = '{v: fv_r[6], coll: coll6_r, negx: negx6_r, negy: negy6_r,
                    ax: ax_r[6], ay: ay_r[6]};

  for (genvar g = 0; g < QW; g++) begin : g_div
    ccot_div_cell u_cell_x (.clk(clk), .lane_in(dx_lane[g]), .lane_out(dx_lane[g+1]));
    ccot_div_cell u_cell_y (.clk(clk), .lane_in(dy_lane[g]), .lane_out(dy_lane[g+1]));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < QW; i++) begin
        sb1_r[i] <= '0;
      end
    end else begin
      sb1_r[0] <= sb1_in;
      for (int i = 1; i < QW; i++) begin
        sb1_r[i] <= sb1_r[i-1];
      end
    end
  end

  // rounding, centre, squaring
  logic [QXW-1:0] qx1, qy1;
  logic [OFF_MAGW-1:0] magx_nxt, magy_nxt;
  sb1_t p1_sb_r, p2_sb_r;
  logic [OFF_MAGW-1:0] magx_r, magy_r;
  logic signed [OXW-1:0] oxs_r, oys_r;
  logic sat2_r;
  logic [2*HIW-1:0] hhx_r, hhy_r;
  logic [HIW+SPLIT-1:0] hlx_r, hly_r;
  logic [2*SPLIT-1:0] llx_r, lly_r;
  logic signed [CSUMW-1:0] sumx, sumy;
  sb2_t p3_sb_r, q3_sb_r;
  logic [SQW-1:0] sqx_r, sqy_r;
  logic [VW-1:0] v_r;
  logic [HIW-1:0] hx, hy;
  logic [SPLIT-1:0] lx, ly;

  always_comb begin
    qx1 = QXW'(dx_lane[QW].quo) +
          QXW'(dx_lane[QW].rem >= dx_lane[QW].den - dx_lane[QW].rem);
    qy1 = QXW'(dy_lane[QW].quo) +
          QXW'(dy_lane[QW].rem >= dy_lane[QW].den - dy_lane[QW].rem);
    magx_nxt = (qx1 > QXW'(OFFSET_LIMIT)) ? OFFSET_LIMIT : qx1[OFF_MAGW-1:0];
    magy_nxt = (qy1 > QXW'(OFFSET_LIMIT)) ? OFFSET_LIMIT : qy1[OFF_MAGW-1:0];
    hx = magx_r[RADW-1:SPLIT];
    hy = magy_r[RADW-1:SPLIT];
    lx = magx_r[SPLIT-1:0];
    ly = magy_r[SPLIT-1:0];
    sumx = CSUMW'(oxs_r) + (CSUMW'(p2_sb_r.ax) <<< FRACTION_BITS);
    sumy = CSUMW'(oys_r) + (CSUMW'(p2_sb_r.ay) <<< FRACTION_BITS);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_sb_r <= '0;
      p2_sb_r <= '0;
      p3_sb_r <= '0;
      q3_sb_r <= '0;
    end else begin
      p1_sb_r <= sb1_r[QW-1];
      p2_sb_r <= p1_sb_r;
      p3_sb_r.v    <= p2_sb_r.v;
      p3_sb_r.coll <= p2_sb_r.coll;
      p3_sb_r.sat  <= sat2_r;
      p3_sb_r.cx   <= (sumx > CSUMW'(CEN_MAX)) ? CEN_MAX :
                      (sumx < CSUMW'(CEN_MIN)) ? CEN_MIN : CENW'(sumx);
      p3_sb_r.cy   <= (sumy > CSUMW'(CEN_MAX)) ? CEN_MAX :
                      (sumy < CSUMW'(CEN_MIN)) ? CEN_MIN : CENW'(sumy);
      q3_sb_r <= p3_sb_r;
    end
  end

  always_ff @(posedge clk) begin
    magx_r <= magx_nxt;
    magy_r <= magy_nxt;

    oxs_r  <= p1_sb_r.negx ? -OXW'(magx_r) : OXW'(magx_r);
    oys_r  <= p1_sb_r.negy ? -OXW'(magy_r) : OXW'(magy_r);
    sat2_r <= (magx_r >= RAD_LIMIT) || (magy_r >= RAD_LIMIT);
    hhx_r  <= (2*HIW)'(hx) * (2*HIW)'(hx);
    hhy_r  <= (2*HIW)'(hy) * (2*HIW)'(hy);
    hlx_r  <= (HIW+SPLIT)'(hx) * (HIW+SPLIT)'(lx);
    hly_r  <= (HIW+SPLIT)'(hy) * (HIW+SPLIT)'(ly);
    llx_r  <= (2*SPLIT)'(lx) * (2*SPLIT)'(lx);
    lly_r  <= (2*SPLIT)'(ly) * (2*SPLIT)'(ly);

    sqx_r <= (SQW'(hhx_r) << (2*SPLIT)) + (SQW'(hlx_r) << (SPLIT+1)) + SQW'(llx_r);
    sqy_r <= (SQW'(hhy_r) << (2*SPLIT)) + (SQW'(hly_r) << (SPLIT+1)) + SQW'(lly_r);

    v_r <= VW'(sqx_r) + VW'(sqy_r);
  end

  // square root chain
  sqrt_lane_t sq_lane [RTW+1];
  sb2_t       sb2_r [RTW];

  assign sq_lane[0] = '{rem: '0, root: '0, val: v_r};

  for (genvar g = 0; g < RTW; g++) begin : g_sqrt
    ccot_sqrt_cell u_cell (.clk(clk), .lane_in(sq_lane[g]), .lane_out(sq_lane[g+1]));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < RTW; i++) begin
        sb2_r[i] <= '0;
      end
    end else begin
      sb2_r[0] <= q3_sb_r;
      for (int i = 1; i < RTW; i++) begin
        sb2_r[i] <= sb2_r[i-1];
      end
    end
  end

  // output register
  logic [RTW:0]    s1;
  logic [RADW-1:0] rad;
  sb2_t            sbo;
  logic            out_strobe_r;
  out_item_t       out_result_r;

  always_comb begin
    sbo = sb2_r[RTW-1];
    s1  = (RTW+1)'(sq_lane[RTW].root) +
          (RTW+1)'(sq_lane[RTW].rem > RW'(sq_lane[RTW].root));
    rad = (sbo.sat || (|s1[RTW:RADW])) ? RAD_MAX : s1[RADW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= sbo.v;
    end
  end

  always_ff @(posedge clk) begin
    if (sbo.coll) begin
      out_result_r <= '{centre_x: '0, centre_y: '0, circle_radius: '0, is_collinear: 1'b1};
    end else begin
      out_result_r <= '{centre_x: sbo.cx, centre_y: sbo.cy, circle_radius: rad,
                        is_collinear: 1'b0};
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_result = out_result_r;

endmodule

/* rtl/ccot_div_cell.sv */
module ccot_div_cell (
  input  logic                  clk,
  input  ccot_pkg::div_lane_t   lane_in,
  output ccot_pkg::div_lane_t   lane_out
);
  import ccot_pkg::*;

  div_lane_t    lane_r;
  div_lane_t    lane_nxt;
  logic [DMW:0] part;
  logic [DMW:0] diff;
  logic         ge;

  always_comb begin
    part         = {lane_in.rem, lane_in.num[QW-1]};
    diff         = part - {1'b0, lane_in.den};
    ge           = part >= {1'b0, lane_in.den};
    lane_nxt.rem = ge ? diff[DMW-1:0] : part[DMW-1:0];
    lane_nxt.quo = {lane_in.quo[QW-2:0], ge};
    lane_nxt.num = {lane_in.num[QW-2:0], 1'b0};
    lane_nxt.den = lane_in.den;
  end

  always_ff @(posedge clk) begin
    lane_r <= lane_nxt;
  end

  assign lane_out = lane_r;

endmodule

/* rtl/ccot_sqrt_cell.sv */
module ccot_sqrt_cell (
  input  logic                  clk,
  input  ccot_pkg::sqrt_lane_t  lane_in,
  output ccot_pkg::sqrt_lane_t  lane_out
);
  import ccot_pkg::*;

  sqrt_lane_t    lane_r;
  sqrt_lane_t    lane_nxt;
  logic [RW-1:0] part;
  logic [RW-1:0] trial;
  logic          ge;

  always_comb begin
    part          = {lane_in.rem[RW-3:0], lane_in.val[VW-1:VW-2]};
    trial         = RW'({lane_in.root, 2'b01});
    ge            = part >= trial;
    lane_nxt.rem  = ge ? part - trial : part;
    lane_nxt.root = {lane_in.root[RTW-2:0], ge};
    lane_nxt.val  = {lane_in.val[VW-3:0], 2'b00};
  end

  always_ff @(posedge clk) begin
    lane_r <= lane_nxt;
  end

  assign lane_out = lane_r;

endmodule
